// ----- hw/rtl/ufpfc_pkg.sv -----
// Shared types and constants for the serial FIFO pair with flow control.
package ufpfc_pkg;

    localparam int LEVEL_W     = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        CMD_LINE_BYTE  = 2'd0,
        CMD_HOST_READ  = 2'd1,
        CMD_HOST_WRITE = 2'd2,
        CMD_TX_REQUEST = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RX_FULL  = 2'd1,
        ST_TX_FULL  = 2'd2,
        ST_RD_EMPTY = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_CTS_ASSERT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTS_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TX_ROOM     = 2'd2;

    localparam logic [LEVEL_W-1:0] CTS_ASSERT_RST  = 7'd54;
    localparam logic [LEVEL_W-1:0] CTS_RELEASE_RST = 7'd50;
    localparam logic [LEVEL_W-1:0] TX_ROOM_RST     = 7'd48;

    // Everything of a result except the two bytes, which come from the memories.
    typedef struct packed {
        logic                read_valid;
        logic                send_valid;
        logic [LEVEL_W-1:0]  rx_level;
        logic [LEVEL_W-1:0]  tx_level;
        logic                tx_has_room;
        logic                tx_over_limit;
        logic                cts_hold;
        logic                break_seen;
        logic                driver_enable;
        status_t             status;
    } info_t;

endpackage

// ----- hw/rtl/uart_fifo_pair_flow_control_unit.sv -----
// Top level: serial-line/host FIFO pair with clear-to-send and driver control.
// A result passes from its input transfer through the read stage
// (state update and memory read) and then through the output register.
// Throughput: one item per cycle while m_tready stays high; the result stage
// stalls the input side only when the output register is full and not taken.
// Reset (aresetn, synchronous, active low) empties both FIFOs, clears the hold,
// break and driver flags and loads the default thresholds; memories are not cleared.
module uart_fifo_pair_flow_control_unit #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // settings write port
    input  logic                                cfg_wr_en,
    input  logic [ufpfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ufpfc_pkg::LEVEL_W-1:0]       cfg_wdata,
    // commands in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] command, [9:2] data_byte, [10] frame_error, [15:11] zero
    input  logic [ufpfc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // results out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] read_byte, [8] read_valid, [16:9] send_byte, [17] send_valid,
    // [24:18] rx_level, [31:25] tx_level, [32] tx_has_room, [33] tx_over_limit,
    // [34] cts_hold, [35] break_seen, [36] driver_enable, [38:37] status, [39] zero
    output logic [ufpfc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import ufpfc_pkg::*;

    localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    logic             in_xfer, advance;
    logic             pend_reg, pend_next;
    info_t            info, info_reg;
    logic             m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic             rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [RX_AW-1:0] rx_wr_addr, rx_rd_addr;
    logic [TX_AW-1:0] tx_wr_addr, tx_rd_addr;
    logic [7:0]       wr_data, rx_rd_data, tx_rd_data;
    logic [7:0]       read_byte, send_byte;

    // Output register free, or being emptied this cycle.
    assign advance  = !m_tvalid_reg || m_tready;
    // Stage holding the memory read may take a new transfer when it moves on.
    assign s_tready = !pend_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    ufpfc_ctrl #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH),
        .RX_AW    (RX_AW),
        .TX_AW    (TX_AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (in_xfer),
        .cmd         (cmd_t'(s_tdata[1:0])),
        .data_byte   (s_tdata[9:2]),
        .frame_error (s_tdata[10]),
        .rx_wr_en    (rx_wr_en),
        .rx_wr_addr  (rx_wr_addr),
        .rx_rd_en    (rx_rd_en),
        .rx_rd_addr  (rx_rd_addr),
        .tx_wr_en    (tx_wr_en),
        .tx_wr_addr  (tx_wr_addr),
        .tx_rd_en    (tx_rd_en),
        .tx_rd_addr  (tx_rd_addr),
        .wr_data     (wr_data),
        .info        (info)
    );

    // Read data only changes on a new pop, so it holds while the result stalls.
    ufpfc_byte_ram #(.DEPTH(RX_DEPTH), .AW(RX_AW)) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (wr_data),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    ufpfc_byte_ram #(.DEPTH(TX_DEPTH), .AW(TX_AW)) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (wr_data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    always_comb begin
        pend_next = pend_reg;
        if (in_xfer) begin
            pend_next = 1'b1;
        end else if (advance) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            info_reg <= info;
        end
    end

    // unused byte fields read as zero
    assign read_byte = info_reg.read_valid ? rx_rd_data : 8'd0;
    assign send_byte = info_reg.send_valid ? tx_rd_data : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pend_reg && advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg && advance) begin
            m_tdata_reg <= {1'b0, info_reg.status, info_reg.driver_enable,
                            info_reg.break_seen, info_reg.cts_hold,
                            info_reg.tx_over_limit, info_reg.tx_has_room,
                            info_reg.tx_level, info_reg.rx_level,
                            info_reg.send_valid, send_byte,
                            info_reg.read_valid, read_byte};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_xfer_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> pend_reg)
        else $error("accepted transfer not held in read stage");
    a_one_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !(info_reg.read_valid && info_reg.send_valid))
        else $error("two pops from one command");
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && (info_reg.read_valid || info_reg.send_valid))
        |-> (info_reg.status == ST_OK))
        else $error("pop reported with error status");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && advance) |=> m_tvalid_reg)
        else $error("result lost between read stage and output");

endmodule

// ----- hw/rtl/ufpfc_byte_ram.sv -----
// Byte-wide synchronous memory, one write and one registered read port.
module ufpfc_byte_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/ufpfc_ctrl.sv -----
// Pointers, levels, flags and settings; drives both FIFO memories.
module ufpfc_ctrl #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64,
    parameter int RX_AW    = 6,
    parameter int TX_AW    = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ufpfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ufpfc_pkg::LEVEL_W-1:0]       cfg_wdata,
    input  logic                                accept,
    input  ufpfc_pkg::cmd_t                     cmd,
    input  logic [7:0]                          data_byte,
    input  logic                                frame_error,
    output logic                                rx_wr_en,
    output logic [RX_AW-1:0]                    rx_wr_addr,
    output logic                                rx_rd_en,
    output logic [RX_AW-1:0]                    rx_rd_addr,
    output logic                                tx_wr_en,
    output logic [TX_AW-1:0]                    tx_wr_addr,
    output logic                                tx_rd_en,
    output logic [TX_AW-1:0]                    tx_rd_addr,
    output logic [7:0]                          wr_data,
    output ufpfc_pkg::info_t                    info
);

    import ufpfc_pkg::*;

    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_LW = (RX_CW > LEVEL_W) ? RX_CW : LEVEL_W;
    localparam int TX_LW = (TX_CW > LEVEL_W) ? TX_CW : LEVEL_W;

    logic [LEVEL_W-1:0] cts_assert_reg, cts_release_reg, tx_room_reg;

    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic [TX_CW-1:0] tx_count_reg, tx_count_next;
    logic             hold_reg, hold_next, break_reg, break_next, drv_reg, drv_next;

    logic             rx_push, rx_pop, tx_push, tx_pop;
    logic [RX_LW-1:0] rx_lvl_ext;
    logic [TX_LW-1:0] tx_lvl_ext;
    status_t          status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cts_assert_reg  <= CTS_ASSERT_RST;
            cts_release_reg <= CTS_RELEASE_RST;
            tx_room_reg     <= TX_ROOM_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CTS_ASSERT:  cts_assert_reg  <= cfg_wdata;
                REG_CTS_RELEASE: cts_release_reg <= cfg_wdata;
                REG_TX_ROOM:     tx_room_reg     <= cfg_wdata;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    assign rx_push = accept && (cmd == CMD_LINE_BYTE) && !frame_error
                     && (rx_count_reg < RX_CW'(RX_DEPTH));
    assign rx_pop  = accept && (cmd == CMD_HOST_READ) && (rx_count_reg != '0);
    assign tx_push = accept && (cmd == CMD_HOST_WRITE)
                     && (tx_count_reg < TX_CW'(TX_DEPTH));
    assign tx_pop  = accept && (cmd == CMD_TX_REQUEST) && (tx_count_reg != '0);

    always_comb begin
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_count_next = rx_count_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_count_next = tx_count_reg;
        hold_next     = hold_reg;
        break_next    = break_reg;
        drv_next      = drv_reg;
        status        = ST_OK;

        if (rx_push) begin
            rx_tail_next  = (rx_tail_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_reg + 1'b1;
            rx_count_next = rx_count_reg + 1'b1;
            if (RX_LW'(rx_count_next) > RX_LW'(cts_assert_reg)) begin
                hold_next = 1'b1;
            end
        end
        if (rx_pop) begin
            rx_head_next  = (rx_head_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_reg + 1'b1;
            rx_count_next = rx_count_reg - 1'b1;
            if (RX_LW'(rx_count_next) < RX_LW'(cts_release_reg)) begin
                hold_next = 1'b0;
            end
        end
        if (tx_push) begin
            tx_tail_next  = (tx_tail_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_reg + 1'b1;
            tx_count_next = tx_count_reg + 1'b1;
            drv_next      = 1'b1;
        end
        if (tx_pop) begin
            tx_head_next  = (tx_head_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_reg + 1'b1;
            tx_count_next = tx_count_reg - 1'b1;
        end

        if (accept) begin
            case (cmd)
                CMD_LINE_BYTE: begin
                    if (frame_error) begin
                        break_next = 1'b1;
                    end else if (!rx_push) begin
                        status = ST_RX_FULL;
                    end
                end
                CMD_HOST_READ: begin
                    if (!rx_pop) status = ST_RD_EMPTY;
                end
                CMD_HOST_WRITE: begin
                    if (!tx_push) status = ST_TX_FULL;
                end
                CMD_TX_REQUEST: begin
                    if (!tx_pop) drv_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            rx_count_reg <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            tx_count_reg <= '0;
            hold_reg     <= 1'b0;
            break_reg    <= 1'b0;
            drv_reg      <= 1'b0;
        end else begin
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_count_reg <= rx_count_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_count_reg <= tx_count_next;
            hold_reg     <= hold_next;
            break_reg    <= break_next;
            drv_reg      <= drv_next;
        end
    end

    assign rx_wr_en   = rx_push;
    assign rx_wr_addr = rx_tail_reg;
    assign rx_rd_en   = rx_pop;
    assign rx_rd_addr = rx_head_reg;
    assign tx_wr_en   = tx_push;
    assign tx_wr_addr = tx_tail_reg;
    assign tx_rd_en   = tx_pop;
    assign tx_rd_addr = tx_head_reg;
    assign wr_data    = data_byte;

    // levels past 127 are reported modulo 128
    assign rx_lvl_ext = RX_LW'(rx_count_next);
    assign tx_lvl_ext = TX_LW'(tx_count_next);

    always_comb begin
        info.read_valid    = rx_pop;
        info.send_valid    = tx_pop;
        info.rx_level      = rx_lvl_ext[LEVEL_W-1:0];
        info.tx_level      = tx_lvl_ext[LEVEL_W-1:0];
        info.tx_has_room   = TX_LW'(tx_count_next) < TX_LW'(tx_room_reg);
        info.tx_over_limit = TX_LW'(tx_count_next) > TX_LW'(tx_room_reg);
        info.cts_hold      = hold_next;
        info.break_seen    = break_next;
        info.driver_enable = drv_next;
        info.status        = status;
    end

    a_hold_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_push && !hold_reg && (RX_LW'(rx_count_next) > RX_LW'(cts_assert_reg)))
        |=> hold_reg)
        else $error("hold not raised above assert level");
    a_rx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= RX_CW'(RX_DEPTH))
        else $error("receive count beyond depth");
    a_tx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_count_reg <= TX_CW'(TX_DEPTH))
        else $error("transmit count beyond depth");
    a_rx_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_count_reg == '0) |-> (rx_head_reg == rx_tail_reg))
        else $error("receive pointers disagree with empty count");

endmodule
